### rtl/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
`default_nettype none

package wsfd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpcodeW = 4;
  localparam int unsigned LenW    = 64;
  localparam int unsigned KeyW    = 32;

  localparam logic [7:0] OpcodeMask = 8'h0F;
  localparam logic [7:0] MaskFlag   = 8'h80;
  localparam logic [7:0] LenCodeMsk = 8'h7F;
  localparam logic [6:0] LenCode16  = 7'd126;
  localparam logic [6:0] LenCode64  = 7'd127;

  localparam logic [2:0] Ext16Last  = 3'd1;
  localparam logic [2:0] Ext64Last  = 3'd7;
  localparam logic [2:0] KeyLast    = 3'd3;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_MASK  = 3'd4,
    PH_DATA  = 3'd5
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0]   payload_byte;
    logic [OpcodeW-1:0] frame_opcode;
    logic               carries_byte;
    logic               frame_end;
  } result_t;

endpackage

`default_nettype wire

### rtl/wsfd_parser.sv
// Frame header parser and payload unmasking state machine.
`default_nettype none

module wsfd_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  output logic                  res_valid_o,
  output wsfd_pkg::result_t     res_o
);
  import wsfd_pkg::*;

  phase_e             phase_q, phase_d;
  logic [2:0]         count_q, count_d;
  logic [OpcodeW-1:0] opcode_q, opcode_d;
  logic               masked_q, masked_d;
  logic [LenW-1:0]    remain_q, remain_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [1:0]         pos_q, pos_d;
  logic [6:0]         code;
  logic [7:0]         key_byte;
  logic               last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      count_q  <= '0;
      opcode_q <= '0;
      masked_q <= 1'b0;
      remain_q <= '0;
      key_q    <= '0;
      pos_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      opcode_q <= opcode_d;
      masked_q <= masked_d;
      remain_q <= remain_d;
      key_q    <= key_d;
      pos_q    <= pos_d;
    end
  end

  always_comb begin
    case (pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign code = byte_i[6:0] & LenCodeMsk[6:0];
  assign last = (remain_q[LenW-1:1] == '0);

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    opcode_d    = opcode_q;
    masked_d    = masked_q;
    remain_d    = remain_q;
    key_d       = key_q;
    pos_d       = pos_q;
    res_valid_o = 1'b0;
    res_o       = '{payload_byte: '0, frame_opcode: opcode_q,
                    carries_byte: 1'b0, frame_end: 1'b1};
    case (phase_q)
      PH_HDR1: begin
        masked_d = (byte_i & MaskFlag) != 8'h00;
        key_d    = '0;
        count_d  = '0;
        remain_d = '0;
        if (code == LenCode16) begin
          phase_d = PH_EXT16;
        end else if (code == LenCode64) begin
          phase_d = PH_EXT64;
        end else begin
          remain_d = {{(LenW-7){1'b0}}, code};
          pos_d    = '0;
          if (masked_d) begin
            phase_d = PH_MASK;
          end else if (code == 7'd0) begin
            phase_d     = PH_HDR0;
            res_valid_o = 1'b1;
          end else begin
            phase_d = PH_DATA;
          end
        end
      end
      PH_EXT16, PH_EXT64: begin
        remain_d = {remain_q[LenW-9:0], byte_i};
        if ((phase_q == PH_EXT16 && count_q >= Ext16Last) ||
            (phase_q == PH_EXT64 && count_q >= Ext64Last)) begin
          count_d = '0;
          pos_d   = '0;
          if (masked_q) begin
            phase_d = PH_MASK;
          end else if (remain_d == '0) begin
            phase_d     = PH_HDR0;
            res_valid_o = 1'b1;
          end else begin
            phase_d = PH_DATA;
          end
        end else begin
          count_d = count_q + 3'd1;
        end
      end
      PH_MASK: begin
        key_d = {key_q[KeyW-9:0], byte_i};
        if (count_q >= KeyLast) begin
          count_d = '0;
          pos_d   = '0;
          if (remain_q == '0) begin
            phase_d     = PH_HDR0;
            res_valid_o = 1'b1;
          end else begin
            phase_d = PH_DATA;
          end
        end else begin
          count_d = count_q + 3'd1;
        end
      end
      PH_DATA: begin
        pos_d       = pos_q + 2'd1;
        remain_d    = last ? '0 : remain_q - {{(LenW-1){1'b0}}, 1'b1};
        res_valid_o = 1'b1;
        res_o.payload_byte = masked_q ? (byte_i ^ key_byte) : byte_i;
        res_o.carries_byte = 1'b1;
        res_o.frame_end    = last;
        if (last) begin
          phase_d = PH_HDR0;
        end
      end
      default: begin
        opcode_d = byte_i[3:0] & OpcodeMask[3:0];
        phase_d  = PH_HDR1;
      end
    endcase
  end

  a_marker_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_valid_o && !res_o.carries_byte) |-> res_o.frame_end)
    else $error("empty-frame marker without frame end");

  a_hdr0_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PH_HDR0) |-> !res_valid_o)
    else $error("result on first header byte");

  a_frame_end_to_hdr0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_valid_o && res_o.frame_end) |=> (phase_q == PH_HDR0))
    else $error("frame end did not return to header");

  a_data_pos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q != PH_DATA && phase_d == PH_DATA) |=> (pos_q == 2'd0))
    else $error("mask position not cleared at payload start");

endmodule

`default_nettype wire

### rtl/wsfd_out_fifo.sv
// Two-entry result buffer between the parser and the output channel.
`default_nettype none

module wsfd_out_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire wsfd_pkg::result_t data_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output wsfd_pkg::result_t     data_o
);
  import wsfd_pkg::*;

  result_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = count_q != 2'd0;
  assign full_o      = count_q == 2'd2;
  assign data_o      = mem_q[rd_q];

  always_comb begin
    count_d = count_q;
    case ({push_i, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full result buffer");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_q == rd_q))
    else $error("pointers disagree with count");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer count overflow");

endmodule

`default_nettype wire

### rtl/websocket_frame_deframer_unit.sv
// Top level of the WebSocket frame deframer: input register, parser, result buffer.
// Input channel: rx_byte_i with in_valid_i / in_stall_o; one stream byte per item.
// Output channel: payload_byte_o, frame_opcode_o, carries_byte_o, frame_end_o with
// out_valid_o / out_stall_i. Each payload byte yields one item, unmasked with the
// frame's key; a frame of zero length yields one marker item with carries_byte_o
// low and frame_end_o high. Header, length and key bytes yield nothing else.
// Path: an item accepted into the input register is parsed combinationally and its
// result is written into the result buffer, which presents it on the output.
// Throughput: one byte per cycle, sustained while the receiver does not stall;
// the parser state update (a 64-bit length decrement and zero test) sets the cycle.
// A two-entry result buffer sits before the output; when it is full the input
// register holds its byte and in_stall_o rises, so nothing is lost when the
// receiver stalls. in_stall_o does not depend on out_stall_i in the same cycle.
// Reset (rst_ni low, asynchronous) returns the parser to awaiting the first
// header byte and empties the input register and the result buffer.
`default_nettype none

module websocket_frame_deframer_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      payload_byte_o,
  output logic [3:0]      frame_opcode_o,
  output logic            carries_byte_o,
  output logic            frame_end_o
);
  import wsfd_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       full, advance, accept, res_valid;
  result_t    res, out_res;

  assign advance    = in_valid_q && !full;
  assign in_stall_o = in_valid_q && full;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_valid_d = accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  wsfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsfd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance && res_valid),
    .data_i      (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (out_res)
  );

  assign payload_byte_o = out_res.payload_byte;
  assign frame_opcode_o = out_res.frame_opcode;
  assign carries_byte_o = out_res.carries_byte;
  assign frame_end_o    = out_res.frame_end;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("stall without a held item");

  a_held_byte_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("held input byte changed");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !carries_byte_o) |-> (payload_byte_o == 8'h00))
    else $error("marker item carries data");

endmodule

`default_nettype wire
